@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MLFE_ASSERT_HOLD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold at the next edge.
`define MLFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mlfe_pkg.sv @@
// Constants for the marker/length frame extractor.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package mlfe_pkg;

  localparam int MAX_PAYLOAD    = 32;
  localparam int HEADER_BYTES   = 4;
  localparam int FRAME_OVERHEAD = 5;
  localparam int WINDOW_DEPTH   = MAX_PAYLOAD + HEADER_BYTES;
  localparam int SCAN_DEPTH     = WINDOW_DEPTH + 1;

  // circular byte store, power-of-two deep so pointers wrap for free
  localparam int PTR_W     = $clog2(SCAN_DEPTH);
  localparam int MEM_DEPTH = 1 << PTR_W;
  localparam int FILL_W    = $clog2(SCAN_DEPTH + 1);

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7E;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h21;

endpackage

`default_nettype wire

@@ rtl/marker_length_frame_extractor.sv @@
// Marker/length frame extractor: received bytes are held in a circular byte
// store and scanned for start marker, type, sender, length, payload, end marker.
// One byte request is taken at a time, only in idle; no new byte is taken
// until the scan that it starts has returned to idle. The scan reads the byte
// at the head and drops it while it is not the start marker, then reads type,
// sender and length, then checks the end marker; each result waits while the
// output stalls, and the scan goes back to idle once the store runs empty or
// holds an incomplete frame. The byte store has a single registered read
// port, so every byte examined is one read. A byte that only extends a
// pending frame still starts a scan from the head. A rescan after a bad frame
// drops its start byte and can release frames hidden behind it.
// No clearing pass after reset: only bytes already written are read.
// Depends on mlfe_pkg.
`default_nettype none

module marker_length_frame_extractor
  import mlfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  // received bytes
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [BYTE_W-1:0] rx_byte,
  // extracted results
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [BYTE_W-1:0] frame_type,
  output      logic [BYTE_W-1:0] sender_id,
  output      logic [LEN_W-1:0]  payload_length,
  output      logic [BYTE_W-1:0] payload_byte,
  output      logic              payload_valid,
  output      logic              last_of_frame
);

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_SEEK_RD    = 9'b000000010,
    ST_SEEK_CHK   = 9'b000000100,
    ST_HDR_TYPE   = 9'b000001000,
    ST_HDR_SENDER = 9'b000010000,
    ST_HDR_LEN    = 9'b000100000,
    ST_END_CHK    = 9'b001000000,
    ST_EMIT       = 9'b010000000,
    ST_EMIT_LOAD  = 9'b100000000
  } state_t;

  state_t              state;
  logic [BYTE_W-1:0]   start_marker;
  logic [BYTE_W-1:0]   end_marker;
  logic [PTR_W-1:0]    head;
  logic [FILL_W-1:0]   fill;
  logic [BYTE_W-1:0]   type_q;
  logic [BYTE_W-1:0]   sender_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    idx;

  logic [BYTE_W-1:0]   mem [MEM_DEPTH];
  logic [BYTE_W-1:0]   rd_data;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    wr_addr;

  logic                cfg_wr;
  logic                in_acc;
  logic                out_free;
  logic [LEN_W-1:0]    cur_len;
  logic [FILL_W-1:0]   flen_rd;
  logic [FILL_W-1:0]   flen_q;
  logic                last_res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign wr_addr  = head + PTR_W'(fill);

  // length byte as returned by the store; meaningful only when within range
  assign cur_len  = rd_data[LEN_W-1:0];
  assign flen_rd  = FILL_W'(cur_len) + FILL_W'(FRAME_OVERHEAD);
  assign flen_q   = FILL_W'(len_q) + FILL_W'(FRAME_OVERHEAD);
  // an empty frame gives a single result
  assign last_res = ({1'b0, idx} + (LEN_W+1)'(1)) >= {1'b0, len_q};

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_START_MARKER: prdata = DATA_W'(start_marker);
      REG_END_MARKER:   prdata = DATA_W'(end_marker);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      ST_SEEK_RD: begin
        rd_en   = (fill != '0);
        rd_addr = head;
      end
      ST_SEEK_CHK: begin
        // type byte is only needed once a full header is held
        rd_en   = (fill >= FILL_W'(HEADER_BYTES));
        rd_addr = head + PTR_W'(1);
      end
      ST_HDR_TYPE: begin
        rd_en   = 1'b1;
        rd_addr = head + PTR_W'(2);
      end
      ST_HDR_SENDER: begin
        rd_en   = 1'b1;
        rd_addr = head + PTR_W'(3);
      end
      ST_HDR_LEN: begin
        rd_en   = (rd_data <= BYTE_W'(MAX_PAYLOAD)) && (fill >= flen_rd);
        rd_addr = head + PTR_W'(cur_len) + PTR_W'(FRAME_OVERHEAD - 1);
      end
      ST_EMIT: begin
        rd_en   = out_free;
        rd_addr = head + PTR_W'(HEADER_BYTES) + PTR_W'(idx);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = head;
      end
    endcase
  end

  // byte store: written only in idle, read only while scanning, so no overlap
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wr_addr] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
      head         <= '0;
      fill         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_START_MARKER: start_marker <= pwdata[BYTE_W-1:0];
          REG_END_MARKER:   end_marker   <= pwdata[BYTE_W-1:0];
          default:          ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            fill  <= fill + FILL_W'(1);
            state <= ST_SEEK_RD;
          end
        end
        ST_SEEK_RD: begin
          state <= (fill == '0) ? ST_IDLE : ST_SEEK_CHK;
        end
        ST_SEEK_CHK: begin
          if (rd_data != start_marker) begin
            head  <= head + PTR_W'(1);
            fill  <= fill - FILL_W'(1);
            state <= ST_SEEK_RD;
          end else if (fill < FILL_W'(HEADER_BYTES)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_HDR_TYPE;
          end
        end
        ST_HDR_TYPE: begin
          type_q <= rd_data;
          state  <= ST_HDR_SENDER;
        end
        ST_HDR_SENDER: begin
          sender_q <= rd_data;
          state    <= ST_HDR_LEN;
        end
        ST_HDR_LEN: begin
          if (rd_data > BYTE_W'(MAX_PAYLOAD)) begin
            // oversize: drop the start byte and rescan
            head  <= head + PTR_W'(1);
            fill  <= fill - FILL_W'(1);
            state <= ST_SEEK_RD;
          end else if (fill < flen_rd) begin
            state <= ST_IDLE;
          end else begin
            len_q <= cur_len;
            state <= ST_END_CHK;
          end
        end
        ST_END_CHK: begin
          if (rd_data != end_marker) begin
            head  <= head + PTR_W'(1);
            fill  <= fill - FILL_W'(1);
            state <= ST_SEEK_RD;
          end else begin
            idx   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_EMIT_LOAD;
          end
        end
        ST_EMIT_LOAD: begin
          out_valid      <= 1'b1;
          frame_type     <= type_q;
          sender_id      <= sender_q;
          payload_length <= len_q;
          payload_valid  <= (len_q != '0);
          payload_byte   <= (len_q != '0) ? rd_data : '0;
          last_of_frame  <= last_res;
          if (last_res) begin
            head  <= head + PTR_W'(flen_q);
            fill  <= fill - flen_q;
            state <= ST_SEEK_RD;
          end else begin
            idx   <= idx + LEN_W'(1);
            state <= ST_EMIT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mlfe_checker.sv @@
// Port-level checks for marker_length_frame_extractor, bound to the top level.
// Depends on mlfe_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mlfe_checker
  import mlfe_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] frame_type,
  input wire logic [LEN_W-1:0]  payload_length,
  input wire logic [BYTE_W-1:0] payload_byte,
  input wire logic              payload_valid,
  input wire logic              last_of_frame
);

  // one byte request is scanned before the next is taken
  `MLFE_ASSERT_NEXT(a_one_request, clk, rst, in_valid && in_ready, !in_ready, "request taken while scanning")

  // an empty frame is a single, closing result with no data
  `MLFE_ASSERT_HOLD(a_empty_frame, clk, rst, out_valid && !payload_valid |-> last_of_frame && payload_length == '0 && payload_byte == '0, "malformed empty-frame result")

  `MLFE_ASSERT_HOLD(a_len_range, clk, rst, out_valid && payload_valid |-> payload_length != '0 && payload_length <= LEN_W'(MAX_PAYLOAD), "payload length out of range")

  `MLFE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(frame_type), "stalled result changed")

endmodule

bind marker_length_frame_extractor mlfe_checker u_mlfe_checker (.*);

`default_nettype wire

@@ sim/marker_length_frame_extractor_test.sv @@
// Testbench for marker_length_frame_extractor: byte stream in, frame results out,
// checked against a built-in window/rescan predictor. Depends on mlfe_pkg and the RTL.
module marker_length_frame_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfe_pkg::*;

  localparam int DRAIN_CYCLES      = 400;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int PHASE_BYTES       = 50;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct {
    byte_t             frame_type;
    byte_t             sender_id;
    logic [LEN_W-1:0]  payload_length;
    byte_t             payload_byte;
    logic              payload_valid;
    logic              last_of_frame;
  } frame_result_t;

  localparam byte_t DIRECTED_BYTES [25] = '{
    // empty frame, extreme type and sender
    START_MARKER_RST, 8'h00, 8'hFF, 8'h00, END_MARKER_RST,
    // length one past the maximum: leading marker dropped, window cleared
    START_MARKER_RST, 8'hFF, 8'h00, byte_t'(MAX_PAYLOAD + 1),
    // outer frame with a bad end hides two good frames, released by one byte
    START_MARKER_RST, 8'hA5, 8'h5A, 8'h0B,
    START_MARKER_RST, 8'h01, 8'h02, 8'h00, END_MARKER_RST,
    START_MARKER_RST, 8'h03, 8'h04, 8'h01, 8'hFF, END_MARKER_RST,
    8'h55
  };

  class frame_scoreboard;
    byte_t         start_marker;
    byte_t         end_marker;
    byte_t         held[$];
    frame_result_t expected[$];
    int            fails;

    function new();
      start_marker = START_MARKER_RST;
      end_marker   = END_MARKER_RST;
      fails        = 0;
    endfunction

    // append one byte, pull out every complete frame, keep the rest
    function void note_byte(byte_t b);
      byte_t         scan[$];
      frame_result_t r;
      int            h;
      int            len;
      int            flen;
      int            i;
      scan = held;
      scan.insert(scan.size(), b);
      h = 0;
      while (h < scan.size()) begin
        while (h < scan.size() && scan[h] != start_marker) h++;
        if (scan.size() - h < HEADER_BYTES) break;
        len = scan[h+3];
        if (len > MAX_PAYLOAD) begin
          h++;
          continue;
        end
        flen = len + FRAME_OVERHEAD;
        if (scan.size() - h < flen) break;
        if (scan[h+flen-1] != end_marker) begin
          h++;
          continue;
        end
        r.frame_type     = scan[h+1];
        r.sender_id      = scan[h+2];
        r.payload_length = len[LEN_W-1:0];
        if (len == 0) begin
          r.payload_byte  = '0;
          r.payload_valid = 1'b0;
          r.last_of_frame = 1'b1;
          expected.insert(expected.size(), r);
        end else begin
          for (i = 0; i < len; i++) begin
            r.payload_byte  = scan[h+HEADER_BYTES+i];
            r.payload_valid = 1'b1;
            r.last_of_frame = (i == len - 1);
            expected.insert(expected.size(), r);
          end
        end
        h += flen;
      end
      held.delete();
      for (i = h; i < scan.size(); i++) held.insert(held.size(), scan[i]);
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected.size() == 0) begin
        $error("unexpected result: type %0h sender %0h byte %0h",
               got.frame_type, got.sender_id, got.payload_byte);
        fails++;
        return;
      end
      want = expected[0];
      expected.delete(0);
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("sender_id", want.sender_id, got.sender_id);
      compare_field("payload_length", BYTE_W'(want.payload_length), BYTE_W'(got.payload_length));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_valid", BYTE_W'(want.payload_valid), BYTE_W'(got.payload_valid));
      compare_field("last_of_frame", BYTE_W'(want.last_of_frame), BYTE_W'(got.last_of_frame));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  byte_t             rx_byte;
  logic              out_valid;
  logic              out_ready;
  byte_t             frame_type;
  byte_t             sender_id;
  logic [LEN_W-1:0]  payload_length;
  byte_t             payload_byte;
  logic              payload_valid;
  logic              last_of_frame;

  frame_scoreboard sb;
  int              send_idle;
  int              recv_idle;
  int              bytes_sent;
  int              stall_left;
  bit              long_stall_req;

  marker_length_frame_extractor DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_type     (frame_type),
    .sender_id      (sender_id),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .payload_valid  (payload_valid),
    .last_of_frame  (last_of_frame)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_stall_req) begin
      stall_left     = LONG_STALL_CYCLES;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : monitor
    frame_result_t seen;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready) begin
        seen.frame_type     = frame_type;
        seen.sender_id      = sender_id;
        seen.payload_length = payload_length;
        seen.payload_byte   = payload_byte;
        seen.payload_valid  = payload_valid;
        seen.last_of_frame  = last_of_frame;
        sb.check_result(seen);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(byte_t b);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    bytes_sent++;
  endtask

  task automatic send_frame(byte_t ftype, byte_t sender, int len, bit good_end);
    int i;
    send_byte(sb.start_marker);
    send_byte(ftype);
    send_byte(sender);
    send_byte(byte_t'(len));
    for (i = 0; i < len; i++) send_byte(byte_t'($urandom));
    if (good_end) send_byte(sb.end_marker);
    else send_byte(sb.end_marker ^ byte_t'($urandom_range(255, 1)));
  endtask

  // mostly well-formed frames, some noise, bad ends and oversize lengths
  task automatic send_traffic(int n_bytes);
    int stop_at;
    int pick;
    int size_pick;
    int len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_byte(byte_t'($urandom));
      end else if (pick < 22) begin
        send_byte(sb.start_marker);
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom_range(255, MAX_PAYLOAD + 1)));
      end else begin
        size_pick = $urandom_range(19);
        if (size_pick == 0) len = MAX_PAYLOAD;
        else if (size_pick < 4) len = $urandom_range(MAX_PAYLOAD);
        else len = $urandom_range(5);
        send_frame(byte_t'($urandom), byte_t'($urandom), len, pick >= 35);
      end
    end
  endtask

  // wait out the last result and any scan still running on a dropped frame
  task automatic settle();
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_marker(logic reg_idx, byte_t value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (reg_idx == REG_START_MARKER) sb.start_marker = value;
    else sb.end_marker = value;
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    rx_byte        = '0;
    out_ready      = 1'b0;
    bytes_sent     = 0;
    stall_left     = 0;
    long_stall_req = 1'b0;
    send_idle      = 36;
    recv_idle      = 52;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    send_traffic(PHASE_BYTES);
    settle();

    write_marker(REG_START_MARKER, 8'h00);
    write_marker(REG_END_MARKER, 8'hFF);
    send_traffic(PHASE_BYTES);
    settle();

    write_marker(REG_START_MARKER, 8'hFF);
    write_marker(REG_END_MARKER, 8'h00);
    send_idle = 52;
    recv_idle = 36;
    send_traffic(PHASE_BYTES);
    settle();

    write_marker(REG_START_MARKER, byte_t'($urandom));
    write_marker(REG_END_MARKER, byte_t'($urandom));
    send_idle      = 0;
    recv_idle      = 0;
    // output held off while bytes keep coming, so the input backs up
    long_stall_req = 1'b1;
    send_traffic(PHASE_BYTES);
    settle();

    if (sb.fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
